// ===== design/command_frame_receiver_macros.svh =====
// Assertion macros of the command frame receiver; used by crx_emitter.
// Depends on nothing; included by the files that carry assertions.
`ifndef COMMAND_FRAME_RECEIVER_MACROS_SVH
`define COMMAND_FRAME_RECEIVER_MACROS_SVH

`ifndef SYNTHESIS
// expr must never be true
`define CFR_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
// ante implies cons in the same cycle
`define CFR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// ante implies cons in the next cycle
`define CFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CFR_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`define CFR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define CFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== design/crx_pkg.sv =====
// Shared types and constants of the command frame receiver.
// Depends on nothing; imported by every module of the block.
package crx_pkg;

    localparam int FRAME_LENGTH = 10;
    localparam int CNT_W        = 6;
    localparam int EMIT_W       = $clog2(FRAME_LENGTH + 1);

    localparam logic [7:0] HDR0 = 8'h5E;
    localparam logic [7:0] HDR1 = 8'h0C;

    localparam logic [2:0] CFG_CAR_ID       = 3'd0;
    localparam logic [2:0] CFG_PRIORITY     = 3'd1;
    localparam logic [2:0] CFG_TASK_CODE    = 3'd2;
    localparam logic [2:0] CFG_AVOID_CODE   = 3'd3;
    localparam logic [2:0] CFG_STOP_CODE    = 3'd4;
    localparam logic [2:0] CFG_ADVANCE_CODE = 3'd5;
    localparam logic [2:0] CFG_REPLY_CODE   = 3'd6;

    typedef enum logic [2:0] {
        CMD_TASK    = 3'd0,
        CMD_AVOID   = 3'd1,
        CMD_STOP    = 3'd2,
        CMD_ADVANCE = 3'd3,
        CMD_NONE    = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [7:0] car_id;
        logic [7:0] priority_cfg;
        logic [7:0] task_code;
        logic [7:0] avoid_code;
        logic [7:0] stop_code;
        logic [7:0] advance_code;
        logic [7:0] reply_code;
    } cfg_t;

    // Everything the emitter needs to send one reply frame and report
    typedef struct packed {
        logic [7:0]  car_id;
        logic [7:0]  reply_code;
        logic [7:0]  priority_cfg;
        logic [15:0] reply_sum;
        cmd_t        command;
        logic [15:0] coord_x;
        logic [15:0] coord_y;
    } job_t;

endpackage

// ===== design/command_frame_receiver.sv =====
// Top level of the command frame receiver: config registers, parser, emitter.
// Depends on crx_pkg, crx_cfg_regs, crx_parser and crx_emitter.
//
//   channel  direction  tdata / data                 tuser / index   tlast
//   s_       in         rx_byte                      frame_start     -
//   m_       out        tx_byte,command,coord_x,y    out_kind        last
//   cfg_     in         cfg_data (8 bits)            cfg_index (3)   -
//
// One byte is accepted per cycle while s_tready is high; the parser updates count,
// sum and fields in one pass. A good frame ends in a job that the emitter turns into
// FRAME_LENGTH + 1 result items, one per cycle through the output register, paced
// by m_tready. s_tready drops only while a finished job waits for the emitter, which
// holds one. Reset is synchronous on aresetn low and clears counters, flags and valids;
// config registers return to their documented values.
module command_frame_receiver import crx_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  logic        s_tuser,    // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // [7:0] tx_byte, [10:8] command,
                                    // [26:11] coord_x, [42:27] coord_y, rest 0
    output logic        m_tuser,    // [0] out_kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    cfg_t cfg;
    logic job_valid;
    logic job_ready;
    job_t job;

    crx_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    crx_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    crx_emitter u_emitter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== design/crx_cfg_regs.sv =====
// Configuration register file of the command frame receiver.
// Depends on crx_pkg.
module crx_cfg_regs import crx_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    output cfg_t       cfg
);

    cfg_t cfg_reg, cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_CAR_ID:       cfg_next.car_id       = cfg_data;
                CFG_PRIORITY:     cfg_next.priority_cfg = cfg_data;
                CFG_TASK_CODE:    cfg_next.task_code    = cfg_data;
                CFG_AVOID_CODE:   cfg_next.avoid_code   = cfg_data;
                CFG_STOP_CODE:    cfg_next.stop_code    = cfg_data;
                CFG_ADVANCE_CODE: cfg_next.advance_code = cfg_data;
                CFG_REPLY_CODE:   cfg_next.reply_code   = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.car_id       <= 8'd1;
            cfg_reg.priority_cfg <= 8'd0;
            cfg_reg.task_code    <= 8'd1;
            cfg_reg.avoid_code   <= 8'd2;
            cfg_reg.stop_code    <= 8'd3;
            cfg_reg.advance_code <= 8'd4;
            cfg_reg.reply_code   <= 8'd5;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== design/crx_parser.sv =====
// Per-byte frame parser: byte count, running sum, header/id check, field capture.
// Depends on crx_pkg; hands a finished good frame to the emitter as a job.
module crx_parser import crx_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    input  logic       s_tuser,   // [0] frame_start
    output logic       job_valid,
    input  logic       job_ready,
    output job_t       job
);

    localparam logic [CNT_W-1:0] LEN_CNT  = CNT_W'(FRAME_LENGTH);
    localparam logic [CNT_W-1:0] CHK_HI   = CNT_W'(FRAME_LENGTH - 2);
    localparam logic [CNT_W-1:0] CHK_LO   = CNT_W'(FRAME_LENGTH - 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [15:0]      sum_reg, sum_next;
    logic             hdr_ok_reg, hdr_ok_next;
    logic [7:0]       cmd_byte_reg, cmd_byte_next;
    logic [15:0]      x_reg, x_next;
    logic [15:0]      y_reg, y_next;
    logic [7:0]       check_hi_reg, check_hi_next;
    logic             job_valid_reg, job_valid_next;
    job_t             job_reg, job_next;

    logic [7:0]       rx_byte;
    logic             accept;
    logic             active;
    logic [CNT_W-1:0] idx;
    logic             good;
    cmd_t             cmd_dec;
    logic [15:0]      reply_sum;

    assign rx_byte   = s_tdata;
    assign s_tready  = !job_valid_reg || job_ready;
    assign accept    = s_tvalid && s_tready;
    assign active    = s_tuser || (count_reg != '0 && count_reg < LEN_CNT);
    assign idx       = s_tuser ? '0 : count_reg;
    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    assign good = hdr_ok_reg && ({check_hi_reg, rx_byte} == sum_reg);
    assign reply_sum = 16'(HDR0) + 16'(HDR1) + 16'(cfg.car_id)
                     + 16'(cfg.reply_code) + 16'(cfg.priority_cfg);

    // task wins over avoid, avoid over stop, stop over advance
    always_comb begin
        priority if (cmd_byte_reg == cfg.task_code)    cmd_dec = CMD_TASK;
        else if (cmd_byte_reg == cfg.avoid_code)       cmd_dec = CMD_AVOID;
        else if (cmd_byte_reg == cfg.stop_code)        cmd_dec = CMD_STOP;
        else if (cmd_byte_reg == cfg.advance_code)     cmd_dec = CMD_ADVANCE;
        else                                           cmd_dec = CMD_NONE;
    end

    always_comb begin
        count_next     = count_reg;
        sum_next       = sum_reg;
        hdr_ok_next    = hdr_ok_reg;
        cmd_byte_next  = cmd_byte_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        check_hi_next  = check_hi_reg;
        job_next       = job_reg;
        job_valid_next = job_valid_reg && !job_ready;

        if (accept && active) begin
            count_next  = idx + 1'b1;
            sum_next    = s_tuser ? 16'd0 : sum_reg;
            hdr_ok_next = s_tuser ? 1'b1 : hdr_ok_reg;
            if (idx < CHK_HI) begin
                sum_next = sum_next + 16'(rx_byte);
            end
            if (idx == CNT_W'(0) && rx_byte != HDR0)        hdr_ok_next = 1'b0;
            if (idx == CNT_W'(1) && rx_byte != HDR1)        hdr_ok_next = 1'b0;
            if (idx == CNT_W'(2) && rx_byte != cfg.car_id)  hdr_ok_next = 1'b0;
            if (idx == CNT_W'(3)) cmd_byte_next = rx_byte;
            if (idx == CNT_W'(4)) x_next[15:8] = rx_byte;
            if (idx == CNT_W'(5)) x_next[7:0]  = rx_byte;
            if (idx == CNT_W'(6)) y_next[15:8] = rx_byte;
            if (idx == CNT_W'(7)) y_next[7:0]  = rx_byte;
            if (idx == CHK_HI)    check_hi_next = rx_byte;
            if (idx == CHK_LO && good) begin
                job_valid_next        = 1'b1;
                job_next.car_id       = cfg.car_id;
                job_next.reply_code   = cfg.reply_code;
                job_next.priority_cfg = cfg.priority_cfg;
                job_next.reply_sum    = reply_sum;
                job_next.command      = cmd_dec;
                job_next.coord_x      = x_reg;
                job_next.coord_y      = y_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            sum_reg       <= '0;
            hdr_ok_reg    <= 1'b0;
            job_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            hdr_ok_reg    <= hdr_ok_next;
            job_valid_reg <= job_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_byte_reg <= cmd_byte_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        check_hi_reg <= check_hi_next;
        job_reg      <= job_next;
    end

endmodule

// ===== design/crx_emitter.sv =====
// Reply emitter: sends the reply frame bytes and the command report of one job.
// Depends on crx_pkg and the assertion macros header.
`include "command_frame_receiver_macros.svh"
module crx_emitter import crx_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        job_valid,
    output logic        job_ready,
    input  job_t        job,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] tx_byte, [10:8] command,
                                   // [26:11] coord_x, [42:27] coord_y, rest 0
    output logic        m_tuser,   // [0] out_kind
    output logic        m_tlast    // last
);

    localparam logic [EMIT_W-1:0] K_REPORT = EMIT_W'(FRAME_LENGTH);
    localparam logic [EMIT_W-1:0] K_SUM_HI = EMIT_W'(FRAME_LENGTH - 2);
    localparam logic [EMIT_W-1:0] K_SUM_LO = EMIT_W'(FRAME_LENGTH - 1);

    logic              busy_reg, busy_next;
    logic [EMIT_W-1:0] k_reg, k_next;
    job_t              job_reg, job_next;
    logic              tvalid_reg, tvalid_next;
    logic              kind_reg, kind_next;
    logic [7:0]        tx_reg, tx_next;
    cmd_t              cmd_reg, cmd_next;
    logic [15:0]       x_reg, x_next;
    logic [15:0]       y_reg, y_next;
    logic              last_reg, last_next;

    logic              out_free;
    logic [7:0]        tx_byte;

    assign out_free  = !tvalid_reg || m_tready;
    assign job_ready = !busy_reg;
    assign m_tvalid  = tvalid_reg;
    assign m_tuser   = kind_reg;
    assign m_tlast   = last_reg;
    assign m_tdata   = {5'd0, y_reg, x_reg, cmd_reg, tx_reg};

    always_comb begin
        priority if (k_reg == EMIT_W'(0)) tx_byte = HDR0;
        else if (k_reg == EMIT_W'(1))     tx_byte = HDR1;
        else if (k_reg == EMIT_W'(2))     tx_byte = job_reg.car_id;
        else if (k_reg == EMIT_W'(3))     tx_byte = job_reg.reply_code;
        else if (k_reg == EMIT_W'(4))     tx_byte = job_reg.priority_cfg;
        else if (k_reg == K_SUM_HI)       tx_byte = job_reg.reply_sum[15:8];
        else if (k_reg == K_SUM_LO)       tx_byte = job_reg.reply_sum[7:0];
        else                              tx_byte = 8'd0;
    end

    always_comb begin
        busy_next   = busy_reg;
        k_next      = k_reg;
        job_next    = job_reg;
        tvalid_next = tvalid_reg && !m_tready;
        kind_next   = kind_reg;
        tx_next     = tx_reg;
        cmd_next    = cmd_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        last_next   = last_reg;

        if (!busy_reg) begin
            if (job_valid) begin
                busy_next = 1'b1;
                k_next    = '0;
                job_next  = job;
            end
        end else if (out_free) begin
            tvalid_next = 1'b1;
            k_next      = k_reg + 1'b1;
            if (k_reg == K_REPORT) begin
                busy_next = 1'b0;
                kind_next = 1'b1;
                tx_next   = 8'd0;
                cmd_next  = job_reg.command;
                x_next    = job_reg.coord_x;
                y_next    = job_reg.coord_y;
                last_next = 1'b1;
            end else begin
                kind_next = 1'b0;
                tx_next   = tx_byte;
                cmd_next  = CMD_NONE;
                x_next    = 16'd0;
                y_next    = 16'd0;
                last_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            k_reg      <= '0;
            tvalid_reg <= 1'b0;
        end else begin
            busy_reg   <= busy_next;
            k_reg      <= k_next;
            tvalid_reg <= tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg  <= job_next;
        kind_reg <= kind_next;
        tx_reg   <= tx_next;
        cmd_reg  <= cmd_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        last_reg <= last_next;
    end

    `CFR_ASSERT_NEVER(a_k_range, aclk, aresetn, busy_reg && (k_reg > K_REPORT), "item index past report")
    `CFR_ASSERT_SAME(a_report_last, aclk, aresetn, tvalid_reg, (kind_reg == last_reg), "report and last disagree")
    `CFR_ASSERT_NEXT(a_job_taken, aclk, aresetn, job_valid && job_ready, busy_reg && (k_reg == '0), "job not started")

endmodule
